>>> design/sfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types and constants for the sync word frame deframer.
// ----------------------------------------------------------------------------
package sfd_pkg;

    localparam int          MAX_PAYLOAD        = 2048;
    localparam int          HEADER_BYTES_DFLT  = 8;
    localparam int          SYNC_LEN           = 2;
    localparam int          INFO_BYTES         = 5;
    localparam int          LEN_W              = 12;
    localparam int          INDEX_W            = 11;
    localparam int          INFO_W             = 8 * INFO_BYTES;

    localparam logic [7:0]  SYNC_FIRST         = 8'hA5;
    localparam logic [7:0]  SYNC_SECOND        = 8'h5A;
    localparam logic [7:0]  TYPE_RAW           = 8'h00;
    localparam logic [7:0]  TYPE_DELTA         = 8'h01;

    localparam logic        KIND_PAYLOAD       = 1'b0;
    localparam logic        KIND_DROP          = 1'b1;

    localparam logic [LEN_W-1:0] LEN_RAW_RST   = 12'd1024;
    localparam logic [LEN_W-1:0] LEN_DELTA_RST = 12'd512;

    typedef enum logic {
        REG_PAYLOAD_LEN_RAW   = 1'b0,
        REG_PAYLOAD_LEN_DELTA = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        PH_HUNT1,
        PH_HUNT2,
        PH_HEADER,
        PH_PAYLOAD
    } phase_t;

    typedef struct packed {
        logic               kind;
        logic [7:0]         payload_byte;
        logic [7:0]         frame_type;
        logic [INFO_W-1:0]  frame_info;
        logic [INDEX_W-1:0] byte_index;
        logic               last;
    } sfd_result_t;

    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] res;
        res = len;
        if (32'(len) > MAX_PAYLOAD)
        begin
            res = LEN_W'(MAX_PAYLOAD);
        end
        return res;
    endfunction

endpackage

>>> design/sfd_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_parser
// Sync hunt, header capture and payload tagging, one byte per cycle while in_fire is high.
// ----------------------------------------------------------------------------
module sfd_parser
    import sfd_pkg::*;
#(
    parameter int HEADER_BYTES = HEADER_BYTES_DFLT
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_fire,
    input  logic [7:0]       data_byte,
    input  logic [LEN_W-1:0] len_raw,
    input  logic [LEN_W-1:0] len_delta,
    output logic             res_valid,
    output sfd_result_t      res
);

    localparam int HDR_LEN = HEADER_BYTES - SYNC_LEN;
    localparam int HCW     = (HDR_LEN > 1) ? $clog2(HDR_LEN) : 1;

    phase_t                phase_reg, phase_next;
    logic [HCW-1:0]        header_count_reg, header_count_next;
    logic [7:0]            type_hold_reg, type_hold_next;
    logic [INFO_W-1:0]     info_hold_reg, info_hold_next;
    logic [INDEX_W-1:0]    payload_count_reg, payload_count_next;
    logic [LEN_W-1:0]      payload_target_reg, payload_target_next;

    logic                  header_done;
    logic [7:0]            type_cur;
    logic                  type_known;
    logic [LEN_W-1:0]      target_sel;
    logic                  payload_fin;

    always_comb
    begin
        header_done = (32'(header_count_reg) == HDR_LEN - 1);
        // the type byte itself when it is also the last header byte
        type_cur    = (header_count_reg == '0) ? data_byte : type_hold_reg;
        type_known  = (type_cur == TYPE_RAW) || (type_cur == TYPE_DELTA);
        target_sel  = clamp_len((type_cur == TYPE_RAW) ? len_raw : len_delta);
        payload_fin = ({1'b0, payload_count_reg} + 12'd1) >= payload_target_reg;
    end

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (in_fire)
        begin
            unique case (phase_reg)
                PH_HUNT1:
                begin
                    if (data_byte == SYNC_FIRST)
                    begin
                        phase_next = PH_HUNT2;
                    end
                end
                PH_HUNT2:
                begin
                    phase_next = (data_byte == SYNC_SECOND) ? PH_HEADER : PH_HUNT1;
                end
                PH_HEADER:
                begin
                    if (header_done)
                    begin
                        if (type_known && (target_sel != '0))
                        begin
                            phase_next = PH_PAYLOAD;
                        end
                        else
                        begin
                            phase_next = PH_HUNT1;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    if (payload_fin)
                    begin
                        phase_next = PH_HUNT1;
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT1;
                end
            endcase
        end
    end

    // datapath and result
    always_comb
    begin
        header_count_next   = header_count_reg;
        type_hold_next      = type_hold_reg;
        info_hold_next      = info_hold_reg;
        payload_count_next  = payload_count_reg;
        payload_target_next = payload_target_reg;
        res_valid           = 1'b0;
        res.kind            = KIND_PAYLOAD;
        res.payload_byte    = data_byte;
        res.frame_type      = type_hold_reg;
        res.frame_info      = info_hold_reg;
        res.byte_index      = payload_count_reg;
        res.last            = payload_fin;

        if (in_fire)
        begin
            unique case (phase_reg)
                PH_HUNT1:
                begin
                end
                PH_HUNT2:
                begin
                    if (data_byte == SYNC_SECOND)
                    begin
                        header_count_next = '0;
                        type_hold_next    = '0;
                        info_hold_next    = '0;
                    end
                end
                PH_HEADER:
                begin
                    if (header_count_reg == '0)
                    begin
                        type_hold_next = data_byte;
                    end
                    // bytes past the fifth info byte are ignored
                    for (int k = 0; k < INFO_BYTES; k++)
                    begin
                        if (32'(header_count_reg) == k + 1)
                        begin
                            info_hold_next[8*k +: 8] = data_byte;
                        end
                    end
                    header_count_next = header_count_reg + 1'b1;
                    if (header_done)
                    begin
                        header_count_next  = '0;
                        payload_count_next = '0;
                        if (type_known)
                        begin
                            payload_target_next = target_sel;
                        end
                        else
                        begin
                            res_valid        = 1'b1;
                            res.kind         = KIND_DROP;
                            res.payload_byte = '0;
                            res.frame_type   = type_hold_next;
                            res.frame_info   = info_hold_next;
                            res.byte_index   = '0;
                            res.last         = 1'b1;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    res_valid          = 1'b1;
                    payload_count_next = payload_fin ? '0 : payload_count_reg + 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_HUNT1;
            header_count_reg   <= '0;
            type_hold_reg      <= '0;
            info_hold_reg      <= '0;
            payload_count_reg  <= '0;
            payload_target_reg <= '0;
        end
        else
        begin
            phase_reg          <= phase_next;
            header_count_reg   <= header_count_next;
            type_hold_reg      <= type_hold_next;
            info_hold_reg      <= info_hold_next;
            payload_count_reg  <= payload_count_next;
            payload_target_reg <= payload_target_next;
        end
    end

endmodule

>>> design/sfd_out_skid.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_out_skid
// Result register with a skid stage so the input side keeps moving.
// ----------------------------------------------------------------------------
module sfd_out_skid
    import sfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        res_valid,
    input  sfd_result_t res,
    output logic        accept_ok,
    output logic        out_valid,
    input  logic        out_ready,
    output sfd_result_t out_res
);

    logic        out_valid_reg, out_valid_next;
    logic        skid_valid_reg, skid_valid_next;
    sfd_result_t out_res_reg, out_res_next;
    sfd_result_t skid_res_reg, skid_res_next;
    logic        pop;

    always_comb
    begin
        pop             = out_valid_reg && out_ready;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_res_next    = out_res_reg;
        skid_res_next   = skid_res_reg;
        if (skid_valid_reg)
        begin
            // no new result can arrive while the skid entry is held
            if (pop)
            begin
                out_res_next    = skid_res_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (res_valid)
        begin
            if (!out_valid_reg || pop)
            begin
                out_res_next   = res;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_res_next   = res;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg  <= out_res_next;
        skid_res_reg <= skid_res_next;
    end

    assign accept_ok = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

endmodule

>>> design/sync_word_frame_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_word_frame_deframer
// Hunts for the A5 5A sync word, captures the header and tags every payload
// byte with type, info, index and last; unknown types yield one drop result.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  in        input      in_valid / in_ready    data_byte
//  out       output     out_valid / out_ready  kind, payload_byte, frame_type,
//                                              frame_info, byte_index, last
//  cfg       input      cfg_write              cfg_index, cfg_data
//
//  one byte per cycle while in_ready is high; each result is registered before it reaches the output
//  the result register plus one skid entry hold results during output stalls;
//  in_ready drops only while the skid entry is occupied
//  reset clears the hunt state and loads lengths 1024 and 512
// ----------------------------------------------------------------------------
module sync_word_frame_deframer
    import sfd_pkg::*;
#(
    parameter int HEADER_BYTES = HEADER_BYTES_DFLT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         data_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               kind,
    output logic [7:0]         payload_byte,
    output logic [7:0]         frame_type,
    output logic [INFO_W-1:0]  frame_info,
    output logic [INDEX_W-1:0] byte_index,
    output logic               last,
    input  logic               cfg_write,
    input  cfg_index_t         cfg_index,
    input  logic [LEN_W-1:0]   cfg_data
);

    logic [LEN_W-1:0] len_raw_reg;
    logic [LEN_W-1:0] len_delta_reg;
    logic             in_fire;
    logic             res_valid;
    sfd_result_t      res;
    sfd_result_t      out_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_raw_reg   <= LEN_RAW_RST;
            len_delta_reg <= LEN_DELTA_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_PAYLOAD_LEN_RAW:   len_raw_reg   <= cfg_data;
                REG_PAYLOAD_LEN_DELTA: len_delta_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign in_fire = in_valid && in_ready;

    sfd_parser #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .data_byte (data_byte),
        .len_raw   (len_raw_reg),
        .len_delta (len_delta_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    sfd_out_skid u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .accept_ok (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign kind         = out_res.kind;
    assign payload_byte = out_res.payload_byte;
    assign frame_type   = out_res.frame_type;
    assign frame_info   = out_res.frame_info;
    assign byte_index   = out_res.byte_index;
    assign last         = out_res.last;

endmodule
